### rtl/imm_pkg.sv
// Package for the integer matrix multiply unit: types, codes and default sizes.
`default_nettype none
package imm_pkg;

	localparam int MATRIX_SIZE_DEF = 16;
	localparam int IDX_W           = 4;
	localparam int DATA_W          = 32;

	typedef enum logic [1:0] {
		MODE_LOAD_A  = 2'd0,
		MODE_LOAD_B  = 2'd1,
		MODE_COMPUTE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_READ  = 2'd1,
		ST_DRAIN = 2'd2,
		ST_DONE  = 2'd3
	} state_t;

	typedef struct packed {
		logic [1:0]              mode;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_row;
		logic [IDX_W-1:0]         out_col;
		logic signed [DATA_W-1:0] product;
	} result_t;

endpackage
`default_nettype wire

### rtl/integer_matrix_multiply_unit.sv
// Top level of the integer matrix multiply unit with its element stores and MAC sequencer.
// Load words (A or B element) are written on the accepting edge; busy stays low.
// A compute word makes the sequencer read the element pairs, let the multiply stages empty and raise
// done; the result is registered and valid in the same cycle as done. The next word can be accepted
// in the cycle after the strobe; busy holds off new words before it, as the multiplier and adder are shared.
// Reset (arst_n low) returns the sequencer to idle; the element stores are not cleared.
`default_nettype none
module integer_matrix_multiply_unit #(
	parameter int MATRIX_SIZE = imm_pkg::MATRIX_SIZE_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire imm_pkg::cmd_t   cmd,
	output logic                 busy,
	output logic                 done,
	output imm_pkg::result_t     result
);
	import imm_pkg::*;

	// Store depth and index widths all follow from the matrix size.
	localparam int DEPTH = MATRIX_SIZE * MATRIX_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int KIW   = $clog2(MATRIX_SIZE);
	localparam int KW    = KIW + 1;

	// Element stores, one word per matrix entry, row-major.
	logic [DATA_W-1:0] mem_a [DEPTH];
	logic [DATA_W-1:0] mem_b [DEPTH];

	state_t state_q, state_d;

	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [KW-1:0]     k_q;
	logic              rd_vld_s1;
	logic              mul_vld_s2;
	logic [DATA_W-1:0] a_rd_s1;
	logic [DATA_W-1:0] b_rd_s1;
	logic [DATA_W-1:0] mul_s2;
	logic [DATA_W-1:0] acc_q;
	result_t           result_q;

	logic          accept;
	logic          in_range;
	logic          is_load_a;
	logic          is_load_b;
	logic          is_compute;
	logic          issue;
	logic          last_k;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] a_addr;
	logic [AW-1:0] b_addr;

	// A word is taken whenever start is seen while the sequencer is idle.
	assign accept   = start && !busy;
	assign in_range = (int'(cmd.row) < MATRIX_SIZE) && (int'(cmd.col) < MATRIX_SIZE);

	always_comb begin
		is_load_a  = 1'b0;
		is_load_b  = 1'b0;
		is_compute = 1'b0;
		unique case (cmd.mode)
			MODE_LOAD_A:  is_load_a  = 1'b1;
			MODE_LOAD_B:  is_load_b  = 1'b1;
			MODE_COMPUTE: is_compute = 1'b1;
			default: ;
		endcase
	end

	// Row-major addresses; the multiply is by a constant.
	assign wr_addr = AW'(AW'(cmd.row) * AW'(MATRIX_SIZE) + AW'(cmd.col));
	assign a_addr  = AW'(AW'(row_q) * AW'(MATRIX_SIZE) + AW'(k_q[KIW-1:0]));
	assign b_addr  = AW'(AW'(k_q[KIW-1:0]) * AW'(MATRIX_SIZE) + AW'(col_q));

	assign issue  = (state_q == ST_READ);
	assign last_k = (int'(k_q) == MATRIX_SIZE - 1);

	// Loads outside the matrix are dropped. Each store has one write and one read port.
	always_ff @(posedge clk) begin
		if (accept && in_range && is_load_a) begin
			mem_a[wr_addr] <= cmd.value;
		end
		a_rd_s1 <= mem_a[a_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && in_range && is_load_b) begin
			mem_b[wr_addr] <= cmd.value;
		end
		b_rd_s1 <= mem_b[b_addr];
	end

	// The shared multiplier keeps only the low 32 bits, which match the wrapped C product.
	always_ff @(posedge clk) begin
		mul_s2 <= a_rd_s1 * b_rd_s1;
	end

	// Sequencer: read pairs for k = 0..N-1, let the multiply stages empty, then strobe.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_compute) begin
					state_d = in_range ? ST_READ : ST_DONE;
				end
			end
			ST_READ: begin
				if (last_k) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_vld_s1 && !mul_vld_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_vld_s1  <= 1'b0;
			mul_vld_s2 <= 1'b0;
			k_q        <= '0;
		end else begin
			state_q    <= state_d;
			rd_vld_s1  <= issue;
			mul_vld_s2 <= rd_vld_s1;
			if (accept) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + KW'(1);
			end
		end
	end

	// The accumulator starts at zero on every compute word; an out-of-range request
	// goes straight to the strobe and returns that zero.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= cmd.row;
			col_q <= cmd.col;
			acc_q <= '0;
		end else if (mul_vld_s2) begin
			acc_q <= acc_q + mul_s2;
		end
		if (accept && is_compute && !in_range) begin
			result_q.out_row <= cmd.row;
			result_q.out_col <= cmd.col;
			result_q.product <= '0;
		end else if (state_d == ST_DONE && state_q != ST_DONE) begin
			result_q.out_row <= row_q;
			result_q.out_col <= col_q;
			result_q.product <= acc_q;
		end
	end

	assign result = result_q;

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the integer matrix multiply unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

	// The block is built with its default size. With 4-bit indexes and 16 rows and columns,
	// every index lands inside the matrix, so the out-of-range load and compute cases
	// cannot be reached here. The checker still handles them.
	localparam int SIZE = imm_pkg::MATRIX_SIZE_DEF;
	localparam int CELLS = SIZE * SIZE;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1250;
	// The idle limit sits far above the length of a compute and the longest sender gap.
	localparam int IDLE_LIMIT = 2000;

	// The scoreboard keeps its own copy of both element stores. It works out each product
	// element when a compute word is accepted. The block cannot take a load while a compute
	// runs, so the copy always matches what the block sees.
	class product_scoreboard;
		bit [31:0] a_copy[CELLS];
		bit [31:0] b_copy[CELLS];
		bit a_loaded[CELLS];
		bit b_loaded[CELLS];
		int a_row_fill[SIZE];
		int b_col_fill[SIZE];
		imm_pkg::result_t pending_products[$];
		int errors;
		int loads;
		int products_checked;
		int ignored;

		// Dot product of row r of A with column c of B. All arithmetic is done at 32 bits,
		// so every multiply and every add wraps the same way that the hardware does.
		function bit [31:0] dot_row_col(int r, int c);
			bit [31:0] acc;
			acc = '0;
			for (int k = 0; k < SIZE; k++) begin
				acc = acc + a_copy[r * SIZE + k] * b_copy[k * SIZE + c];
			end
			return acc;
		endfunction

		// A product element is safe to ask for only when its row of A and its column of B
		// have been fully loaded since reset.
		function bit is_ready(int r, int c);
			return a_row_fill[r] == SIZE && b_col_fill[c] == SIZE;
		endfunction

		function int outstanding();
			return pending_products.size();
		endfunction

		function void note_word(imm_pkg::cmd_t w);
			int idx;
			bit in_range;
			imm_pkg::result_t want;
			in_range = (int'(w.row) < SIZE) && (int'(w.col) < SIZE);
			idx = int'(w.row) * SIZE + int'(w.col);
			case (w.mode)
			imm_pkg::MODE_LOAD_A: begin
				if (in_range) begin
					if (!a_loaded[idx]) begin
						a_loaded[idx] = 1'b1;
						a_row_fill[w.row]++;
					end
					a_copy[idx] = w.value;
					loads++;
				end else begin
					ignored++;
				end
			end
			imm_pkg::MODE_LOAD_B: begin
				if (in_range) begin
					if (!b_loaded[idx]) begin
						b_loaded[idx] = 1'b1;
						b_col_fill[w.col]++;
					end
					b_copy[idx] = w.value;
					loads++;
				end else begin
					ignored++;
				end
			end
			imm_pkg::MODE_COMPUTE: begin
				want.out_row = w.row;
				want.out_col = w.col;
				want.product = in_range ? dot_row_col(w.row, w.col) : '0;
				pending_products.push_back(want);
			end
			default: begin
				ignored++;
			end
			endcase
		endfunction

		function void check_result(imm_pkg::result_t got);
			imm_pkg::result_t want;
			if (pending_products.size() == 0) begin
				$error("product element (%0d,%0d) = %0d arrived with none outstanding",
					got.out_row, got.out_col, got.product);
				errors++;
				return;
			end
			want = pending_products.pop_front();
			products_checked++;
			if (got.out_row !== want.out_row) begin
				$error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
				errors++;
			end
			if (got.out_col !== want.out_col) begin
				$error("out_col: expected %0d, actual %0d", want.out_col, got.out_col);
				errors++;
			end
			if (got.product !== want.product) begin
				$error("product: expected %0d, actual %0d (element %0d,%0d)",
					want.product, got.product, want.out_row, want.out_col);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	imm_pkg::cmd_t cmd;
	logic busy;
	logic done;
	imm_pkg::result_t result;

	product_scoreboard sb = new();
	int idle_cycles = 0;
	int burst_left = 0;

	integer_matrix_multiply_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// The monitor samples at the rising edge. It sees the values from before the edge, which
	// are the values that the handshake takes effect on. A word is taken when start is high
	// and busy is low. A result is taken in the one cycle that done marks.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_word(cmd);
		end
		if (arst_n && done) begin
			sb.check_result(result);
		end
	end

	// The watchdog ends a run that has stalled. It counts the cycles in which neither a word
	// nor a result has been taken.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timed out after %0d cycles with no progress.", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// This task drives one word and returns at the edge that takes it. Start is left high,
	// so back-to-back words keep it high without lowering it and raising it again.
	task automatic send_word(input logic [1:0] m, input int r, input int c,
			input logic [31:0] v);
		imm_pkg::cmd_t w;
		w.mode = m;
		w.row = r[3:0];
		w.col = c[3:0];
		w.value = v;
		start <= 1'b1;
		cmd <= w;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	// Callers pass a nonzero gap, so start never gets two assignments in one step.
	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// These are the extreme element values. Mixing them in A and B makes products and sums
	// wrap in both directions.
	function automatic logic [31:0] extreme_word(int n);
		case (n % 5)
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return 32'hFFFF_FFFF;
		3: return 32'h0000_0001;
		default: return 32'h0000_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 9) < 2) begin
			return extreme_word($urandom_range(0, 4));
		end
		return $urandom;
	endfunction

	// About half the loads go to an element that has never been written. This fills whole
	// rows and columns quickly, so computes become legal early in the run. The rest of the
	// loads overwrite elements at random.
	function automatic int pick_cell(bit for_a);
		int base;
		int j;
		base = $urandom_range(0, CELLS - 1);
		if ($urandom_range(0, 1)) begin
			for (int i = 0; i < CELLS; i++) begin
				j = (base + i) % CELLS;
				if (for_a ? !sb.a_loaded[j] : !sb.b_loaded[j]) begin
					return j;
				end
			end
		end
		return base;
	endfunction

	// Random stimulus comes in bursts of words with idle gaps between them. About a quarter
	// of the bursts follow the previous one with no gap at all.
	task automatic burst_gap();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				pause($urandom_range(1, 12));
			end
		end
		burst_left--;
	endtask

	initial begin
		int counted;
		int choice;
		int slot;
		int r;
		int c;
		bit found;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		counted = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Row 0 of A and column 0 of B are filled with extreme values, so the
		// first product element overflows. A nonzero value on a compute word must be ignored.
		for (int k = 0; k < SIZE; k++) begin
			send_word(imm_pkg::MODE_LOAD_A, 0, k, extreme_word(k));
		end
		for (int k = 0; k < SIZE; k++) begin
			send_word(imm_pkg::MODE_LOAD_B, k, 0, extreme_word(k + 2));
		end
		send_word(imm_pkg::MODE_COMPUTE, 0, 0, 32'hFFFF_FFFF);
		// An unused-mode word aimed at a loaded element must leave the element unchanged.
		// The next compute would show any change.
		send_word(MODE_UNUSED, 0, 0, 32'h7FFF_FFFF);
		send_word(MODE_UNUSED, 15, 15, 32'h8000_0000);
		send_word(imm_pkg::MODE_COMPUTE, 0, 0, 32'h0000_0000);

		// Random part. Computes are issued only for elements whose row and column have been
		// fully loaded. Unused-mode words are mixed in as noise and are not counted.
		while (counted < RANDOM_WORDS) begin
			burst_gap();
			choice = $urandom_range(0, 99);
			found = 1'b0;
			if (choice < 5) begin
				send_word(MODE_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
			end else begin
				if (choice < 40) begin
					for (int t = 0; t < 8 && !found; t++) begin
						r = $urandom_range(0, SIZE - 1);
						c = $urandom_range(0, SIZE - 1);
						found = sb.is_ready(r, c);
					end
				end
				if (found) begin
					send_word(imm_pkg::MODE_COMPUTE, r, c, $urandom);
				end else if (choice < 70) begin
					slot = pick_cell(1'b1);
					send_word(imm_pkg::MODE_LOAD_A, slot / SIZE, slot % SIZE, pick_value());
				end else begin
					slot = pick_cell(1'b0);
					send_word(imm_pkg::MODE_LOAD_B, slot / SIZE, slot % SIZE, pick_value());
				end
				counted++;
			end
		end
		start <= 1'b0;

		// Wait until every product element has come back. Then allow one more compute time,
		// so that a stray strobe would still be caught.
		while (sb.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (SIZE + 8) @(posedge clk);

		$display("Covered %0d element loads, %0d product elements and %0d ignored words.",
			sb.loads, sb.products_checked, sb.ignored);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
